FILE: sv/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  // Result queue geometry
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  localparam int unsigned LimitW       = 17;
  localparam logic [16:0] LimitReset   = 17'd4096;
  localparam int unsigned TdataOutW    = 32;
  localparam int unsigned TuserOutW    = 4;

  // Frame header constants
  localparam logic [3:0] OpText    = 4'h1;
  localparam logic [3:0] OpBinary  = 4'h2;
  localparam logic [3:0] OpClose   = 4'h8;
  localparam logic [3:0] OpPing    = 4'h9;
  localparam logic [3:0] OpPong    = 4'hA;
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;
  localparam logic [15:0] CtrlMaxLen = 16'd125;
  localparam logic [7:0] PongHdr   = 8'h8A;

  typedef enum logic [3:0] {
    PH_HDR0    = 4'd0,
    PH_HDR1    = 4'd1,
    PH_LEN_HI  = 4'd2,
    PH_LEN_LO  = 4'd3,
    PH_KEY0    = 4'd4,
    PH_KEY1    = 4'd5,
    PH_KEY2    = 4'd6,
    PH_KEY3    = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_CLOSE   = 4'd9,
    PH_SKIP    = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    CLS_TEXT   = 2'd0,
    CLS_BINARY = 2'd1,
    CLS_PING   = 2'd2,
    CLS_PONG   = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_PONG    = 3'd1,
    KIND_CLOSE   = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_LEN64    = 2'd1,
    CAUSE_CTRL_LEN = 2'd2,
    CAUSE_LIMIT    = 2'd3
  } cause_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    logic        is_binary;
    logic [15:0] frame_length;
    cause_e      cause;
  } res_t;

  // Up to two results from one parser step
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

FILE: sv/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input register, parser and result queue.
//
// Receive-side WebSocket deframer. One received byte is taken per request on
// s_axis and the block sustains one byte per clock. A byte is held in an input
// register, parsed once the result queue has room for two results, and its
// results reach m_axis through a four-entry result queue. Text and binary
// payload bytes come out unmasked with tlast on the final one; a ping is
// answered as a pong stream (0x8A, length byte, then the unmasked payload as it
// arrives); pong payloads are swallowed. The byte that completes a ping header
// gives two results at once, so the input stalls only while the queue has fewer
// than two free entries, i.e. when m_axis back-pressures. A close frame, a
// 64-bit length, a control payload over 125 bytes or a data length at or above
// payload_limit gives one close or error result and the parser then ignores all
// further bytes until reset. payload_limit (reset 4096) is written through
// cfg_we_i/cfg_wdata_i; the user must do so only while the block is idle, which
// the block itself does not enforce.
module websocket_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [wsd_pkg::LimitW-1:0]    cfg_wdata_i,   // payload_limit
  // received bytes
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i, // [7:0] in_byte
  // results
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] out_byte, [23:8] frame_length, [25:24] error_cause, [31:26] zero
  output logic [wsd_pkg::TdataOutW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o, // out_last
  // [2:0] out_kind, [3] is_binary
  output logic [wsd_pkg::TuserOutW-1:0] m_axis_tuser_o
);

  logic [wsd_pkg::LimitW-1:0] limit_q;
  logic                       in_valid_q, in_valid_d;
  logic [7:0]                 in_byte_q;
  logic                       s_accept;
  logic                       advance;
  logic                       room;
  wsd_pkg::push_t             push;
  wsd_pkg::res_t              res;

  // the held byte is parsed once the queue can take two results
  assign advance         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      limit_q    <= wsd_pkg::LimitReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  wsd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (advance),
    .in_byte_i  (in_byte_q),
    .limit_i    (limit_q),
    .push_o     (push)
  );

  wsd_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  assign m_axis_tdata_o = {6'd0, res.cause, res.frame_length, res.data};
  assign m_axis_tlast_o = res.last;
  assign m_axis_tuser_o = {res.is_binary, res.kind};

endmodule

FILE: sv/wsd_parser.sv
// Frame parser: header decode, mask key capture and payload unmasking, one byte a step.
module wsd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  input  logic [16:0]          limit_i,
  output wsd_pkg::push_t       push_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  wsd_pkg::class_e class_q, class_d;
  logic            mask_q, mask_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     count_q, count_d;
  logic [31:0]     key_q, key_d;
  logic            halted_q, halted_d;

  logic            step;
  logic [15:0]     len_sel;
  logic            hd_go;
  logic            is_ctrl;
  logic            err_ctrl;
  logic            err_limit;
  logic [7:0]      key_byte;
  logic [15:0]     count_inc;
  logic            pay_last;

  assign step      = in_valid_i && !halted_q;
  assign is_ctrl   = (class_q == wsd_pkg::CLS_PING) || (class_q == wsd_pkg::CLS_PONG);
  assign count_inc = count_q + 16'd1;
  assign pay_last  = (count_inc >= len_q);

  // header completion and its checks
  always_comb begin
    unique case (phase_q)
      wsd_pkg::PH_HDR1:   len_sel = {9'd0, in_byte_i[6:0]};
      wsd_pkg::PH_LEN_LO: len_sel = {len_q[15:8], in_byte_i};
      default:            len_sel = len_q;
    endcase
    hd_go = ((phase_q == wsd_pkg::PH_HDR1) && (in_byte_i[6:0] != wsd_pkg::Len7Ext64) &&
             (in_byte_i[6:0] != wsd_pkg::Len7Ext16) && !in_byte_i[7]) ||
            ((phase_q == wsd_pkg::PH_LEN_LO) && !mask_q) ||
            (phase_q == wsd_pkg::PH_KEY3);
    err_ctrl  = is_ctrl && (len_sel > wsd_pkg::CtrlMaxLen);
    err_limit = !is_ctrl && ({1'b0, len_sel} >= limit_i);
  end

  always_comb begin
    unique case (count_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    class_d  = class_q;
    mask_d   = mask_q;
    len_d    = len_q;
    count_d  = count_q;
    key_d    = key_q;
    halted_d = halted_q;
    if (step) begin
      unique case (phase_q)
        wsd_pkg::PH_HDR0: begin
          if (in_byte_i[3:0] == wsd_pkg::OpText) begin
            class_d = wsd_pkg::CLS_TEXT;
            phase_d = wsd_pkg::PH_HDR1;
          end else if (in_byte_i[3:0] == wsd_pkg::OpBinary) begin
            class_d = wsd_pkg::CLS_BINARY;
            phase_d = wsd_pkg::PH_HDR1;
          end else if (in_byte_i[3:0] == wsd_pkg::OpPing) begin
            class_d = wsd_pkg::CLS_PING;
            phase_d = wsd_pkg::PH_HDR1;
          end else if (in_byte_i[3:0] == wsd_pkg::OpPong) begin
            class_d = wsd_pkg::CLS_PONG;
            phase_d = wsd_pkg::PH_HDR1;
          end else if (in_byte_i[3:0] == wsd_pkg::OpClose) begin
            phase_d = wsd_pkg::PH_CLOSE;
          end else begin
            phase_d = wsd_pkg::PH_SKIP;
          end
        end
        wsd_pkg::PH_HDR1: begin
          mask_d = in_byte_i[7];
          if (in_byte_i[6:0] == wsd_pkg::Len7Ext64) begin
            halted_d = 1'b1;
          end else if (in_byte_i[6:0] == wsd_pkg::Len7Ext16) begin
            phase_d = wsd_pkg::PH_LEN_HI;
          end else begin
            len_d = len_sel;
            if (in_byte_i[7]) begin
              phase_d = wsd_pkg::PH_KEY0;
            end
          end
        end
        wsd_pkg::PH_LEN_HI: begin
          len_d   = {in_byte_i, 8'd0};
          phase_d = wsd_pkg::PH_LEN_LO;
        end
        wsd_pkg::PH_LEN_LO: begin
          len_d = len_sel;
          if (mask_q) begin
            phase_d = wsd_pkg::PH_KEY0;
          end
        end
        wsd_pkg::PH_KEY0: begin
          key_d[31:24] = in_byte_i;
          phase_d      = wsd_pkg::PH_KEY1;
        end
        wsd_pkg::PH_KEY1: begin
          key_d[23:16] = in_byte_i;
          phase_d      = wsd_pkg::PH_KEY2;
        end
        wsd_pkg::PH_KEY2: begin
          key_d[15:8] = in_byte_i;
          phase_d     = wsd_pkg::PH_KEY3;
        end
        wsd_pkg::PH_KEY3: begin
          key_d[7:0] = in_byte_i;
        end
        wsd_pkg::PH_PAYLOAD: begin
          count_d = count_inc;
          if (pay_last) begin
            phase_d = wsd_pkg::PH_HDR0;
          end
        end
        wsd_pkg::PH_CLOSE: begin
          halted_d = 1'b1;
          class_d  = wsd_pkg::CLS_TEXT;
        end
        default: begin
          phase_d = wsd_pkg::PH_HDR0;
        end
      endcase
      // header complete: overrides the phase chosen above
      if (hd_go) begin
        count_d = '0;
        if (err_ctrl || err_limit) begin
          halted_d = 1'b1;
        end else if (len_sel == 16'd0) begin
          phase_d = wsd_pkg::PH_HDR0;
        end else begin
          phase_d = wsd_pkg::PH_PAYLOAD;
        end
      end
    end
  end

  // results
  always_comb begin
    push_o                 = '0;
    push_o.r0.is_binary    = (class_q == wsd_pkg::CLS_BINARY);
    push_o.r1.is_binary    = (class_q == wsd_pkg::CLS_BINARY);
    if (step) begin
      unique case (phase_q)
        wsd_pkg::PH_HDR1, wsd_pkg::PH_LEN_LO, wsd_pkg::PH_KEY3: begin
          if ((phase_q == wsd_pkg::PH_HDR1) && (in_byte_i[6:0] == wsd_pkg::Len7Ext64)) begin
            push_o.cnt     = 2'd1;
            push_o.r0.kind = wsd_pkg::KIND_ERROR;
            push_o.r0.cause = wsd_pkg::CAUSE_LEN64;
          end else if (hd_go) begin
            if (err_ctrl || err_limit) begin
              push_o.cnt             = 2'd1;
              push_o.r0.kind         = wsd_pkg::KIND_ERROR;
              push_o.r0.frame_length = len_sel;
              push_o.r0.cause        = err_ctrl ? wsd_pkg::CAUSE_CTRL_LEN
                                                : wsd_pkg::CAUSE_LIMIT;
            end else if (class_q == wsd_pkg::CLS_PING) begin
              // pong header goes out at once
              push_o.cnt             = 2'd2;
              push_o.r0.kind         = wsd_pkg::KIND_PONG;
              push_o.r0.data         = wsd_pkg::PongHdr;
              push_o.r0.frame_length = len_sel;
              push_o.r1.kind         = wsd_pkg::KIND_PONG;
              push_o.r1.data         = len_sel[7:0];
              push_o.r1.last         = (len_sel == 16'd0);
              push_o.r1.frame_length = len_sel;
            end else if ((class_q != wsd_pkg::CLS_PONG) && (len_sel == 16'd0)) begin
              push_o.cnt     = 2'd1;
              push_o.r0.kind = wsd_pkg::KIND_EMPTY;
            end
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          if (class_q != wsd_pkg::CLS_PONG) begin
            push_o.cnt             = 2'd1;
            push_o.r0.kind         = (class_q == wsd_pkg::CLS_PING) ? wsd_pkg::KIND_PONG
                                                                    : wsd_pkg::KIND_PAYLOAD;
            push_o.r0.data         = mask_q ? (in_byte_i ^ key_byte) : in_byte_i;
            push_o.r0.last         = pay_last;
            push_o.r0.frame_length = len_q;
          end
        end
        wsd_pkg::PH_CLOSE: begin
          push_o.cnt          = 2'd1;
          push_o.r0.kind      = wsd_pkg::KIND_CLOSE;
          push_o.r0.is_binary = 1'b0;
        end
        default: begin
          push_o.cnt = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsd_pkg::PH_HDR0;
      class_q  <= wsd_pkg::CLS_TEXT;
      mask_q   <= 1'b0;
      len_q    <= '0;
      count_q  <= '0;
      key_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      class_q  <= class_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      count_q  <= count_d;
      key_q    <= key_d;
      halted_q <= halted_d;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("parser left the halted state without reset");

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsd_pkg::PH_PAYLOAD) |-> (count_q < len_q))
    else $error("payload phase with byte count at or past frame length");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (push_o.cnt == 2'd0))
    else $error("results produced while halted");
`endif

endmodule

FILE: sv/wsd_res_fifo.sv
// Small result queue: takes up to two results a cycle, gives one when ready_i is high.
module wsd_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wsd_pkg::push_t  push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output wsd_pkg::res_t   res_o
);

  wsd_pkg::res_t                   mem [wsd_pkg::ResDepth];
  logic [wsd_pkg::ResPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [wsd_pkg::ResPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [wsd_pkg::ResCntW-1:0]     count_q, count_d;
  logic                            pop;
  logic [wsd_pkg::ResPtrW-1:0]     wr_ptr_nx;

  assign valid_o   = (count_q != '0);
  assign res_o     = mem[rd_ptr_q];
  assign pop       = valid_o && ready_i;
  // two free entries needed, a step may give two results
  assign room_o    = (count_q <= wsd_pkg::ResCntW'(wsd_pkg::ResDepth - 2));
  assign wr_ptr_nx = wr_ptr_q + wsd_pkg::ResPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + wsd_pkg::ResPtrW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + wsd_pkg::ResPtrW'(pop);
    count_d  = count_q + wsd_pkg::ResCntW'(push_i.cnt) - wsd_pkg::ResCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wr_ptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wsd_pkg::ResCntW'(wsd_pkg::ResDepth))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("results pushed without room");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push_i.cnt == 2'd0)) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count not reduced by a lone pop");
`endif

endmodule
